### rtl/gmps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and the result type of the grid path sum block.
// No dependencies.
package gmps_pkg;

  localparam int SUM_W      = 32;
  localparam int COST_W     = 16;
  localparam int COLS_CFG_W = 11;
  localparam int ROWS_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_COLUMNS_DEFAULT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             sat;
  } result_t;

endpackage

### rtl/gmps_cell.sv
`timescale 1ns / 1ps
// One stage of the row sum line: holds a partial sum and passes it on.
// Depends on gmps_pkg.
module gmps_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic                       insert,
  input  logic [gmps_pkg::SUM_W-1:0] load_value,
  input  logic [gmps_pkg::SUM_W-1:0] prev_value,
  output logic [gmps_pkg::SUM_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= insert ? load_value : prev_value;
    end
  end

endmodule

### rtl/gmps_row_line.sv
`timescale 1ns / 1ps
// Chain of cells forming a delay of one grid row of partial sums.
// New sums enter at a movable position; the oldest leaves at the fixed tail.
// Depends on gmps_pkg and gmps_cell.
module gmps_row_line #(
  parameter int DEPTH = gmps_pkg::MAX_COLUMNS_DEFAULT,
  parameter int COL_W = 10
) (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [COL_W-1:0]           ins_pos,
  input  logic [gmps_pkg::SUM_W-1:0] load_value,
  output logic [gmps_pkg::SUM_W-1:0] tail_value
);

  logic [gmps_pkg::SUM_W-1:0] chain [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [gmps_pkg::SUM_W-1:0] prev;
    logic                       insert;

    if (i == 0) begin : g_head
      assign prev = load_value;
    end else begin : g_body
      assign prev = chain[i-1];
    end

    assign insert = (COL_W'(i) == ins_pos);

    gmps_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .insert     (insert),
      .load_value (load_value),
      .prev_value (prev),
      .value      (chain[i])
    );
  end

  assign tail_value = chain[DEPTH-1];

endmodule

### rtl/gmps_out_skid.sv
`timescale 1ns / 1ps
// Output register with a skid entry, so the input side keeps moving while a
// result waits. Depends on gmps_pkg.
module gmps_out_skid (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  gmps_pkg::result_t          push_data,
  output logic                       full,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gmps_pkg::SUM_W-1:0] path_total,
  output logic                       saturated
);

  logic              skid_valid;
  gmps_pkg::result_t skid_data;
  gmps_pkg::result_t out_data;
  logic              out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (push && out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end
      if (out_take) begin
        out_valid <= skid_valid || push;
      end else if (push) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && push && out_valid && !out_take) begin
      skid_data <= push_data;
    end
    if (out_take && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || out_take)) begin
      out_data <= push_data;
    end
  end

  assign path_total = out_data.total;
  assign saturated  = out_data.sat;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_take) |=> (out_valid && !skid_valid))
    else $error("skid entry lost on drain");
`endif

endmodule

### rtl/grid_min_path_sum.sv
`timescale 1ns / 1ps
// Top level: least right/down path cost over a streamed cost grid.
// Depends on gmps_pkg, gmps_row_line, gmps_out_skid.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   cell_cost[15:0]
//   output   out_valid / out_stall path_total[31:0], saturated
//   config   cfg_write             cfg_index[0], cfg_data[15:0]
//
// One cell per cycle unless stalled; row sum line shifts once per accepted cell.
// The last cell's result is registered at the output, or in the skid entry if busy.
// in_stall rises only while both the output register and its skid entry are full.
// Synchronous reset clears position, running sums' control and the output stage;
// the row sum cells need no clearing as the first row fills them.
module grid_min_path_sum #(
  parameter int MAX_COLUMNS = gmps_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gmps_pkg::COST_W-1:0]     cell_cost,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gmps_pkg::SUM_W-1:0]      path_total,
  output logic                            saturated,
  input  logic                            cfg_write,
  input  logic [gmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W = (CNT_W > gmps_pkg::COLS_CFG_W) ? CNT_W : gmps_pkg::COLS_CFG_W;

  logic [gmps_pkg::COLS_CFG_W-1:0] grid_columns;
  logic [gmps_pkg::ROWS_W-1:0]     grid_rows;
  logic [gmps_pkg::SUM_W-1:0]      left_sum;
  logic [COL_W-1:0]                column_index;
  logic [gmps_pkg::ROWS_W-1:0]     row_index;
  logic                            overflow_seen;

  logic                        accept;
  logic [CNT_W-1:0]            active_cols;
  logic [gmps_pkg::ROWS_W-1:0] active_rows;
  logic [COL_W-1:0]            ins_pos;
  logic [gmps_pkg::SUM_W-1:0]  up_sum;
  logic [gmps_pkg::SUM_W-1:0]  base;
  logic [gmps_pkg::SUM_W:0]    raw_sum;
  logic [gmps_pkg::SUM_W-1:0]  sum;
  logic                        sat_now;
  logic                        last_col;
  logic                        last_row;
  logic                        grid_end;
  gmps_pkg::result_t           result;

  assign accept = in_valid && !in_stall;

  always_comb begin
    if (grid_columns == '0) begin
      active_cols = CNT_W'(1);
    end else if (CMP_W'(grid_columns) > CMP_W'(MAX_COLUMNS)) begin
      active_cols = CNT_W'(MAX_COLUMNS);
    end else begin
      active_cols = CNT_W'(grid_columns);
    end
  end

  assign active_rows = (grid_rows == '0) ? gmps_pkg::ROWS_W'(1) : grid_rows;
  assign ins_pos     = COL_W'(CNT_W'(MAX_COLUMNS) - active_cols);

  always_comb begin
    if (row_index == '0 && column_index == '0) begin
      base = '0;
    end else if (row_index == '0) begin
      base = left_sum;
    end else if (column_index == '0) begin
      base = up_sum;
    end else begin
      base = (up_sum < left_sum) ? up_sum : left_sum;
    end
    raw_sum = {1'b0, base} + (gmps_pkg::SUM_W+1)'(cell_cost);
    sat_now = raw_sum[gmps_pkg::SUM_W];
    sum     = sat_now ? gmps_pkg::SUM_MAX : raw_sum[gmps_pkg::SUM_W-1:0];
  end

  assign last_col = ((CNT_W+1)'(column_index) + (CNT_W+1)'(1)) == (CNT_W+1)'(active_cols);
  assign last_row = (row_index == {gmps_pkg::ROWS_W{1'b1}})
                 || (({1'b0, row_index} + 17'd1) >= {1'b0, active_rows});
  assign grid_end = last_col && last_row;

  assign result.total = sum;
  assign result.sat   = overflow_seen || sat_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= gmps_pkg::COLS_CFG_W'(1);
      grid_rows     <= gmps_pkg::ROWS_W'(1);
      left_sum      <= '0;
      column_index  <= '0;
      row_index     <= '0;
      overflow_seen <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gmps_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data[gmps_pkg::COLS_CFG_W-1:0];
        gmps_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data[gmps_pkg::ROWS_W-1:0];
        default: ;
      endcase
      left_sum      <= '0;
      column_index  <= '0;
      row_index     <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (grid_end) begin
        left_sum      <= '0;
        column_index  <= '0;
        row_index     <= '0;
        overflow_seen <= 1'b0;
      end else begin
        left_sum      <= sum;
        overflow_seen <= overflow_seen || sat_now;
        if (last_col) begin
          column_index <= '0;
          row_index    <= row_index + gmps_pkg::ROWS_W'(1);
        end else begin
          column_index <= column_index + COL_W'(1);
        end
      end
    end
  end

  gmps_row_line #(
    .DEPTH (MAX_COLUMNS),
    .COL_W (COL_W)
  ) u_row_line (
    .clk        (clk),
    .shift      (accept),
    .ins_pos    (ins_pos),
    .load_value (sum),
    .tail_value (up_sum)
  );

  gmps_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && grid_end),
    .push_data  (result),
    .full       (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_total (path_total),
    .saturated  (saturated)
  );

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(column_index) < active_cols)
    else $error("column position beyond grid width");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && grid_end && !cfg_write) |=> (column_index == '0 && row_index == '0
      && !overflow_seen))
    else $error("grid position not restarted after last cell");
`endif

endmodule
